FILE: rtl/ddsl_pkg.sv
// Shared constants and types of the differential-drive slew and scale limiter.
package ddsl_pkg;

   localparam int SPEED_WIDTH_DEF = 16;
   localparam int CFG_WIDTH       = 15;
   localparam int CSR_IDX_WIDTH   = 1;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_ACCEL_LIMIT = 1'b0,
      CSR_MAX_RPM     = 1'b1
   } csr_idx_type;

   localparam logic [CFG_WIDTH-1:0] ACCEL_LIMIT_RST = 15'd160;
   localparam logic [CFG_WIDTH-1:0] MAX_RPM_RST     = 15'd1600;

endpackage

FILE: rtl/ddsl_if.sv
// Channel interfaces of the limiter: wheel command request, result and register write.
interface ddsl_req_if
   import ddsl_pkg::*;
#(
   parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SPEED_WIDTH-1:0] left_cmd;
   logic signed [SPEED_WIDTH-1:0] right_cmd;

   modport source (output valid, left_cmd, right_cmd, input ready);
   modport sink   (input valid, left_cmd, right_cmd, output ready);
endinterface

interface ddsl_rsp_if
   import ddsl_pkg::*;
#(
   parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SPEED_WIDTH-1:0] left_out;
   logic signed [SPEED_WIDTH-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface ddsl_csr_if
   import ddsl_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_WIDTH-1:0] index;
   logic [CFG_WIDTH-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ddsl_div.sv
// Restoring divider that produces one quotient bit per cycle.
module ddsl_div
   import ddsl_pkg::*;
#(
   parameter int SPEED_WIDTH = SPEED_WIDTH_DEF,
   localparam int PW = SPEED_WIDTH + CFG_WIDTH,
   localparam int CW = $clog2(SPEED_WIDTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [PW-1:0]          dividend,
   input  logic [SPEED_WIDTH-1:0] divisor,
   output logic                   done,
   output logic [SPEED_WIDTH-1:0] quotient
);

   logic                   busy_ff;
   logic                   done_ff;
   logic [CW-1:0]          cnt_ff;
   logic [SPEED_WIDTH-1:0] rem_ff;
   logic [SPEED_WIDTH-1:0] quo_ff;
   logic [SPEED_WIDTH:0]   trial;
   logic [SPEED_WIDTH:0]   diff;
   logic                   fits;

   // The quotient is known to fit in SPEED_WIDTH bits, so the upper part of the
   // dividend is already below the divisor and seeds the remainder.
   always_comb begin
      trial = {rem_ff, quo_ff[SPEED_WIDTH-1]};
      diff  = trial - {1'b0, divisor};
      fits  = trial >= {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(SPEED_WIDTH);
            rem_ff  <= SPEED_WIDTH'(dividend >> SPEED_WIDTH);
            quo_ff  <= dividend[SPEED_WIDTH-1:0];
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[SPEED_WIDTH-1:0] : trial[SPEED_WIDTH-1:0];
            quo_ff <= {quo_ff[SPEED_WIDTH-2:0], fits};
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/diff_drive_slew_and_scale_limiter.sv
// Top level of the differential-drive slew and scale limiter.
//
// Each req transaction carries a left and a right wheel speed command in signed
// Q12.4 rpm. Every command is first slew limited against the command issued on
// the previous transaction, by at most accel_limit. If either magnitude then
// exceeds max_rpm, both are scaled by max_rpm over the larger magnitude,
// truncated toward zero. One rsp transaction carries the two limited commands.
// The csr channel writes accel_limit (index 0) and max_rpm (index 1); it is
// always ready and must only be used while no transaction is in flight.
// With scaling, one shared multiplier and one restoring divider are used once per
// wheel, and the divider retires one quotient bit per cycle.
// One transaction is processed at a time; req is ready again as soon as the
// result sits in the output register, even while rsp is stalled.
// A stalled result holds the block in its last step until the receiver takes it.
// Reset clears the previous commands to zero, restores the register defaults
// (160 and 1600) and drops rsp valid.
module diff_drive_slew_and_scale_limiter
   import ddsl_pkg::*;
#(
   parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   ddsl_req_if.sink   req,
   ddsl_rsp_if.source rsp,
   ddsl_csr_if.sink   csr
);

   localparam int WMAX = (SPEED_WIDTH > CFG_WIDTH) ? SPEED_WIDTH : CFG_WIDTH;
   localparam int SW   = WMAX + 2;   // room for previous command plus the slew step
   localparam int MW   = WMAX + 1;   // room to compare magnitudes with max_rpm
   localparam int PW   = SPEED_WIDTH + CFG_WIDTH;

   localparam logic signed [SPEED_WIDTH-1:0] MIN_W = {1'b1, {(SPEED_WIDTH-1){1'b0}}};
   localparam logic signed [SPEED_WIDTH-1:0] TOP_W = ~MIN_W;
   localparam logic signed [SW-1:0]          TOP_S = SW'(TOP_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLEW,
      ST_CHECK,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   state_type                     state_ff;
   logic                          wheel_ff;      // 0 works on left, 1 on right
   logic [CFG_WIDTH-1:0]          accel_ff;
   logic [CFG_WIDTH-1:0]          max_ff;
   logic signed [SPEED_WIDTH-1:0] left_cmd_ff;
   logic signed [SPEED_WIDTH-1:0] right_cmd_ff;
   logic signed [SPEED_WIDTH-1:0] last_left_ff;
   logic signed [SPEED_WIDTH-1:0] last_right_ff;
   logic signed [SPEED_WIDTH-1:0] left_ff;
   logic signed [SPEED_WIDTH-1:0] right_ff;
   logic [SPEED_WIDTH-1:0]        hi_ff;
   logic [PW-1:0]                 prod_ff;
   logic                          rsp_valid_ff;
   logic signed [SPEED_WIDTH-1:0] left_out_ff;
   logic signed [SPEED_WIDTH-1:0] right_out_ff;

   logic signed [SPEED_WIDTH-1:0] slew_cmd;
   logic signed [SPEED_WIDTH-1:0] slew_prev;
   logic signed [SW-1:0]          cmd_s;
   logic signed [SW-1:0]          prev_s;
   logic signed [SW-1:0]          lim_s;
   logic signed [SW-1:0]          err_s;
   logic signed [SW-1:0]          step_s;
   logic signed [SPEED_WIDTH-1:0] slew_in;
   logic [SPEED_WIDTH-1:0]        mag_left;
   logic [SPEED_WIDTH-1:0]        mag_right;
   logic [SPEED_WIDTH-1:0]        mag_sel;
   logic                          over;
   logic [PW-1:0]                 prod_in;
   logic                          div_done;
   logic [SPEED_WIDTH-1:0]        div_quo;
   logic signed [SPEED_WIDTH-1:0] scaled_in;
   logic signed [SPEED_WIDTH-1:0] emit_left;
   logic signed [SPEED_WIDTH-1:0] emit_right;

   // Shared slew unit: it serves the left wheel first and the right wheel on the
   // following cycle. A command that is within reach passes unchanged, even the
   // most negative code; only a stepped value is clamped to the symmetric range.
   always_comb begin
      slew_cmd  = wheel_ff ? right_cmd_ff : left_cmd_ff;
      slew_prev = wheel_ff ? last_right_ff : last_left_ff;
      cmd_s     = SW'(slew_cmd);
      prev_s    = SW'(slew_prev);
      lim_s     = signed'({{(SW-CFG_WIDTH){1'b0}}, accel_ff});
      err_s     = cmd_s - prev_s;
      step_s    = cmd_s;
      priority if (err_s > lim_s) begin
         step_s = prev_s + lim_s;
      end else if (err_s < -lim_s) begin
         step_s = prev_s - lim_s;
      end
      if (step_s > TOP_S) begin
         step_s = TOP_S;
      end else if ((step_s < -TOP_S) && (step_s != cmd_s)) begin
         step_s = -TOP_S;
      end
      slew_in = SPEED_WIDTH'(step_s);
   end

   // Magnitudes of the slewed commands. The most negative code maps to
   // 2^(SPEED_WIDTH-1), which the unsigned width still holds.
   always_comb begin
      mag_left  = left_ff[SPEED_WIDTH-1] ? unsigned'(-left_ff) : unsigned'(left_ff);
      mag_right = right_ff[SPEED_WIDTH-1] ? unsigned'(-right_ff) : unsigned'(right_ff);
      over      = (MW'(mag_left) > MW'(max_ff)) || (MW'(mag_right) > MW'(max_ff));
      mag_sel   = wheel_ff ? mag_right : mag_left;
      prod_in   = PW'(mag_sel) * PW'(max_ff);
   end

   // The quotient is at most max_rpm and below the larger magnitude, so it is
   // always a non-negative value of the field.
   always_comb begin
      if (wheel_ff ? right_ff[SPEED_WIDTH-1] : left_ff[SPEED_WIDTH-1]) begin
         scaled_in = -signed'(div_quo);
      end else begin
         scaled_in = signed'(div_quo);
      end
      emit_left  = (left_ff == MIN_W) ? -TOP_W : left_ff;
      emit_right = (right_ff == MIN_W) ? -TOP_W : right_ff;
   end

   ddsl_div #(
      .SPEED_WIDTH (SPEED_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_DIV_GO),
      .dividend (prod_ff),
      .divisor  (hi_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wheel_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         accel_ff      <= ACCEL_LIMIT_RST;
         max_ff        <= MAX_RPM_RST;
         last_left_ff  <= '0;
         last_right_ff <= '0;
      end else begin
         if (csr.valid) begin
            unique case (csr_idx_type'(csr.index))
               CSR_ACCEL_LIMIT: accel_ff <= csr.data;
               CSR_MAX_RPM:     max_ff   <= csr.data;
               default:         ;
            endcase
         end

         // In the last step the result register is refilled instead.
         if (rsp_valid_ff && rsp.ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  left_cmd_ff  <= req.left_cmd;
                  right_cmd_ff <= req.right_cmd;
                  wheel_ff     <= 1'b0;
                  state_ff     <= ST_SLEW;
               end
            end
            ST_SLEW: begin
               if (!wheel_ff) begin
                  left_ff  <= slew_in;
                  wheel_ff <= 1'b1;
               end else begin
                  right_ff <= slew_in;
                  wheel_ff <= 1'b0;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               hi_ff    <= (mag_right > mag_left) ? mag_right : mag_left;
               state_ff <= over ? ST_MUL : ST_FINISH;
            end
            ST_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  if (!wheel_ff) begin
                     left_ff  <= scaled_in;
                     wheel_ff <= 1'b1;
                     state_ff <= ST_MUL;
                  end else begin
                     right_ff <= scaled_in;
                     wheel_ff <= 1'b0;
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  left_out_ff   <= emit_left;
                  right_out_ff  <= emit_right;
                  last_left_ff  <= emit_left;
                  last_right_ff <= emit_right;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req.ready     = (state_ff == ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.left_out  = left_out_ff;
   assign rsp.right_out = right_out_ff;
   assign csr.ready     = 1'b1;

endmodule

FILE: rtl/ddsl_checker.sv
// Port-level assertions of the limiter and the bind that attaches them.
module ddsl_checker
   import ddsl_pkg::*;
#(
   parameter int SPEED_WIDTH = SPEED_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SPEED_WIDTH-1:0] left_out,
   input logic signed [SPEED_WIDTH-1:0] right_out
);

   localparam logic signed [SPEED_WIDTH-1:0] MIN_W = {1'b1, {(SPEED_WIDTH-1){1'b0}}};

   // A stalled result keeps its values until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_out) && $stable(right_out))
      else $error("stalled result changed");

   // Once a transaction is accepted, req is not ready in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Reset leaves no result pending and the block ready.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

   // Results stay inside the symmetric range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (left_out != MIN_W) && (right_out != MIN_W))
      else $error("result at most negative code");

endmodule

bind diff_drive_slew_and_scale_limiter ddsl_checker #(
   .SPEED_WIDTH (SPEED_WIDTH)
) u_ddsl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .left_out  (rsp.left_out),
   .right_out (rsp.right_out)
);

FILE: tb/tb_top.sv
// Self-checking testbench of the differential-drive slew and scale limiter.
`timescale 1ns / 1ps

module tb_top;
   import ddsl_pkg::*;

   localparam int     SW            = SPEED_WIDTH_DEF;
   localparam longint SPEED_TOP     = (longint'(1) << (SW - 1)) - 1;
   // This leaves a wide margin over the slowest correct run.
   localparam int     CYCLE_LIMIT   = 400000;
   localparam int     SETTLE_CYCLES = 8;
   localparam int     HOLD_CYCLES   = 240;
   // Wait at the end for longer than the scaling path takes.
   localparam int     TAIL_CYCLES   = 2 * (SW + 3) + 20;
   localparam int     CHUNK_ITEMS   = 45;

   typedef logic signed [SW-1:0] speed_type;

   // Kinds of entries in the stimulus queue. Only commands become req transactions.
   typedef enum {
      ITEM_CMD,
      ITEM_CFG,
      ITEM_MODE,
      ITEM_HOLD,
      ITEM_DRAIN
   } item_kind_type;

   typedef struct {
      item_kind_type        kind;
      speed_type            left_cmd;
      speed_type            right_cmd;
      csr_idx_type          idx;
      logic [CFG_WIDTH-1:0] data;
      int                   send_pct;
      int                   recv_pct;
   } pending_item_type;

   typedef struct {
      speed_type left_out;
      speed_type right_out;
   } wheel_pair_type;

   logic clock;
   logic reset;

   ddsl_req_if #(.SPEED_WIDTH(SW)) req_bus ();
   ddsl_rsp_if #(.SPEED_WIDTH(SW)) rsp_bus ();
   ddsl_csr_if                     csr_bus ();

   diff_drive_slew_and_scale_limiter #(
      .SPEED_WIDTH (SW)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   // Stimulus waiting to be driven, and the wheel pairs still owed by the block.
   pending_item_type pending_items[$];
   wheel_pair_type   expected_speeds[$];

   // Our own copy of the block's registers and previous commands.
   longint model_accel;
   longint model_max_rpm;
   longint prev_left;
   longint prev_right;

   // Handshake flags raised at the rising edge and consumed at the falling edge.
   bit     req_fired;
   bit     csr_fired;
   bit     hold_start;
   int     hold_left;
   int     send_idle_pct;
   int     recv_idle_pct;
   int     quiet_cnt;
   int     cycle_cnt;
   int     err_cnt;
   int     cmd_cnt;
   int     cfg_cnt;
   int     checked_cnt;

   // ------------------------------------------------------------------------
   // Prediction helpers. The arithmetic is done in 64 bits so that no
   // intermediate sum or product can wrap at the speed width.
   // ------------------------------------------------------------------------

   // Moves the command toward the request by at most step; only a stepped value is
   // saturated to the symmetric range.
   function automatic longint slew_limit(longint cmd, longint prev, longint step);
      longint err;
      longint v;
      err = cmd - prev;
      if (err > step) begin
         v = prev + step;
      end else if (err < -step) begin
         v = prev - step;
      end else begin
         return cmd;
      end
      if (v > SPEED_TOP) v = SPEED_TOP;
      if (v < -SPEED_TOP) v = -SPEED_TOP;
      return v;
   endfunction

   // Scales the magnitude by max_mag / peak, truncating toward zero, and keeps the sign.
   function automatic longint scale_to_max(longint v, longint peak, longint max_mag);
      longint mag;
      longint q;
      mag = (v < 0) ? -v : v;
      q   = (mag * max_mag) / peak;
      return (v < 0) ? -q : q;
   endfunction

   // Only the most negative value can fall outside the symmetric range here.
   function automatic longint clamp_symmetric(longint v);
      if (v < -SPEED_TOP) return -SPEED_TOP;
      if (v > SPEED_TOP) return SPEED_TOP;
      return v;
   endfunction

   // Random wheel speeds: a mix of full range, moderate, small and extreme values.
   function automatic speed_type pick_speed();
      case ($urandom_range(3))
         0: return speed_type'($urandom);
         1: return speed_type'(int'($urandom_range(24000)) - 12000);
         2: return speed_type'(int'($urandom_range(4000)) - 2000);
         default: begin
            case ($urandom_range(3))
               0: return speed_type'(SPEED_TOP);
               1: return speed_type'(-SPEED_TOP - 1);
               2: return speed_type'(-SPEED_TOP);
               default: return speed_type'(0);
            endcase
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus queue fillers.
   // ------------------------------------------------------------------------
   task automatic push_cmd(input longint l, input longint r);
      pending_item_type it;
      it           = '{default: 0, kind: ITEM_CMD, idx: CSR_ACCEL_LIMIT};
      it.left_cmd  = speed_type'(l);
      it.right_cmd = speed_type'(r);
      pending_items.push_back(it);
   endtask

   task automatic push_cfg(input csr_idx_type idx, input int value);
      pending_item_type it;
      it      = '{default: 0, kind: ITEM_CFG, idx: CSR_ACCEL_LIMIT};
      it.idx  = idx;
      it.data = value[CFG_WIDTH-1:0];
      pending_items.push_back(it);
   endtask

   task automatic push_mode(input int send_pct, input int recv_pct);
      pending_item_type it;
      it          = '{default: 0, kind: ITEM_MODE, idx: CSR_ACCEL_LIMIT};
      it.send_pct = send_pct;
      it.recv_pct = recv_pct;
      pending_items.push_back(it);
   endtask

   task automatic push_marker(input item_kind_type kind);
      pending_item_type it;
      it      = '{default: 0, kind: ITEM_CMD, idx: CSR_ACCEL_LIMIT};
      it.kind = kind;
      pending_items.push_back(it);
   endtask

   // One chunk of random commands under a freshly chosen pair of register values.
   // The extremes of both registers come up often on purpose.
   task automatic push_random_chunk(input int n);
      int accel_val;
      int max_val;
      case ($urandom_range(3))
         0: accel_val = 0;
         1: accel_val = 32767;
         2: accel_val = $urandom_range(1, 400);
         default: accel_val = $urandom_range(32767);
      endcase
      case ($urandom_range(3))
         0: max_val = 1;
         1: max_val = 32767;
         2: max_val = $urandom_range(100, 3000);
         default: max_val = $urandom_range(1, 32767);
      endcase
      push_cfg(CSR_ACCEL_LIMIT, accel_val);
      push_cfg(CSR_MAX_RPM, max_val);
      repeat (n) push_cmd(pick_speed(), pick_speed());
   endtask

   // ------------------------------------------------------------------------
   // Clock and the single reset at the start of the run. Every input is given
   // a known value at time zero.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.left_cmd  = '0;
      req_bus.right_cmd = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Stimulus plan and end of test.
   // ------------------------------------------------------------------------
   initial begin
      // Directed part, in the first idling mix.
      push_mode(25, 72);
      push_cmd(0, 0);
      // Full-scale steps under the reset defaults are cut to one slew step.
      push_cmd(SPEED_TOP, -SPEED_TOP - 1);
      push_cmd(-SPEED_TOP - 1, SPEED_TOP);
      // Widest slew and widest magnitude.
      push_cfg(CSR_ACCEL_LIMIT, 32767);
      push_cfg(CSR_MAX_RPM, 32767);
      push_cmd(SPEED_TOP, 0);
      push_cmd(-1, -1);
      push_cmd(-1, -1);
      // The most negative value passes the slew check and is then scaled.
      push_cmd(-SPEED_TOP - 1, -SPEED_TOP - 1);
      push_cmd(SPEED_TOP, -SPEED_TOP - 1);
      // Scaling keeps the left/right ratio.
      push_cfg(CSR_MAX_RPM, 1000);
      push_cmd(30000, 15000);
      push_cmd(4000, -2000);
      // Smallest legal magnitude limit.
      push_cfg(CSR_MAX_RPM, 1);
      push_cmd(SPEED_TOP, -SPEED_TOP - 1);
      push_cmd(1, -1);
      // A zero magnitude limit forces both outputs to zero.
      push_cfg(CSR_MAX_RPM, 0);
      push_cmd(500, -300);
      push_cmd(0, 0);
      // A zero slew limit freezes both commands.
      push_cfg(CSR_ACCEL_LIMIT, 0);
      push_cfg(CSR_MAX_RPM, 32767);
      push_cmd(20000, -20000);
      push_cmd(-SPEED_TOP - 1, SPEED_TOP);
      // Back to the defaults, right at the magnitude limit.
      push_cfg(CSR_ACCEL_LIMIT, 160);
      push_cfg(CSR_MAX_RPM, 1600);
      push_cmd(160, 160);
      push_cmd(1600, 1600);

      // Random part: the sender idles more lightly first, then the receiver does,
      // then neither idles. A long receiver stall falls inside each of the three mixes.
      push_random_chunk(CHUNK_ITEMS);
      push_marker(ITEM_HOLD);
      push_random_chunk(CHUNK_ITEMS);
      push_random_chunk(CHUNK_ITEMS);

      push_mode(72, 25);
      push_random_chunk(CHUNK_ITEMS);
      push_marker(ITEM_HOLD);
      push_random_chunk(CHUNK_ITEMS);
      push_random_chunk(CHUNK_ITEMS);

      push_mode(0, 0);
      push_random_chunk(CHUNK_ITEMS);
      push_marker(ITEM_HOLD);
      push_random_chunk(CHUNK_ITEMS);
      // Here the sender stops until every outstanding result has come back.
      push_marker(ITEM_DRAIN);
      push_random_chunk(CHUNK_ITEMS);

      @(negedge reset);
      do begin
         @(posedge clock);
      end while (pending_items.size() != 0 || req_bus.valid || csr_bus.valid ||
                 expected_speeds.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Summary: %0d wheel command transactions, %0d register writes, %0d checked.",
               cmd_cnt, cfg_cnt, checked_cnt);
      $display("Summary: three idling mixes, long receiver stalls and extreme register values.");
      if (err_cnt == 0) begin
         $display("diff_drive_slew_and_scale_limiter test passed");
      end else begin
         $display("diff_drive_slew_and_scale_limiter test failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver. Works at the falling edge from the stimulus queue. A command is
   // offered with a random gap; a register write waits until nothing is
   // outstanding and quiet_cnt has reached SETTLE_CYCLES.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : drive_proc
      pending_item_type head;
      logic             next_req_valid;
      logic             next_csr_valid;
      bit               block_quiet;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
      end else begin
         next_req_valid = req_bus.valid;
         next_csr_valid = csr_bus.valid;
         if (req_fired) begin
            next_req_valid = 1'b0;
            req_fired      = 1'b0;
         end
         if (csr_fired) begin
            next_csr_valid = 1'b0;
            csr_fired      = 1'b0;
         end
         block_quiet = (expected_speeds.size() == 0) && (quiet_cnt >= SETTLE_CYCLES);
         if (!next_req_valid && !next_csr_valid && pending_items.size() != 0) begin
            head = pending_items[0];
            case (head.kind)
               ITEM_CMD: begin
                  if ($urandom_range(99) >= send_idle_pct) begin
                     req_bus.left_cmd  <= head.left_cmd;
                     req_bus.right_cmd <= head.right_cmd;
                     next_req_valid     = 1'b1;
                     void'(pending_items.pop_front());
                  end
               end
               ITEM_CFG: begin
                  if (block_quiet) begin
                     csr_bus.index  <= head.idx;
                     csr_bus.data   <= head.data;
                     next_csr_valid  = 1'b1;
                     void'(pending_items.pop_front());
                  end
               end
               ITEM_MODE: begin
                  send_idle_pct = head.send_pct;
                  recv_idle_pct = head.recv_pct;
                  void'(pending_items.pop_front());
               end
               ITEM_HOLD: begin
                  hold_start = 1'b1;
                  void'(pending_items.pop_front());
               end
               ITEM_DRAIN: begin
                  if (block_quiet) void'(pending_items.pop_front());
               end
               default: void'(pending_items.pop_front());
            endcase
         end
         req_bus.valid <= next_req_valid;
         csr_bus.valid <= next_csr_valid;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. Random ready, except during a long hold-off that is counted
   // here; the sender keeps offering commands meanwhile, so the block backs up.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : receive_proc
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left      = hold_left - 1;
      end else if (hold_start) begin
         hold_start     = 1'b0;
         hold_left      = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor. At the rising edge it tracks register writes, predicts the
   // result of every accepted command and checks every accepted result
   // against the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor_proc
      longint         l;
      longint         r;
      longint         al;
      longint         ar;
      longint         peak;
      wheel_pair_type want;
      wheel_pair_type got;
      if (reset) begin
         model_accel   = longint'(ACCEL_LIMIT_RST);
         model_max_rpm = longint'(MAX_RPM_RST);
         prev_left     = 0;
         prev_right    = 0;
         quiet_cnt     = 0;
      end else if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_cnt, expected_speeds.size());
         $display("diff_drive_slew_and_scale_limiter test failed");
         $finish;
      end else begin
         cycle_cnt = cycle_cnt + 1;

         // Register write transaction; only ever issued while nothing is in flight.
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_idx_type'(csr_bus.index))
               CSR_ACCEL_LIMIT: model_accel   = longint'(csr_bus.data);
               CSR_MAX_RPM:     model_max_rpm = longint'(csr_bus.data);
               default: ;
            endcase
            csr_fired = 1'b1;
            cfg_cnt   = cfg_cnt + 1;
         end

         // Command transaction: slew limit each wheel, then scale both if
         // either magnitude exceeds the limit.
         if (req_bus.valid && req_bus.ready) begin
            l  = slew_limit(longint'(req_bus.left_cmd), prev_left, model_accel);
            r  = slew_limit(longint'(req_bus.right_cmd), prev_right, model_accel);
            al = (l < 0) ? -l : l;
            ar = (r < 0) ? -r : r;
            if (al > model_max_rpm || ar > model_max_rpm) begin
               peak = (ar > al) ? ar : al;
               l    = scale_to_max(l, peak, model_max_rpm);
               r    = scale_to_max(r, peak, model_max_rpm);
            end
            prev_left      = clamp_symmetric(l);
            prev_right     = clamp_symmetric(r);
            want.left_out  = speed_type'(prev_left);
            want.right_out = speed_type'(prev_right);
            expected_speeds.push_back(want);
            req_fired = 1'b1;
            cmd_cnt   = cmd_cnt + 1;
         end

         // Result transaction.
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.left_out  = rsp_bus.left_out;
            got.right_out = rsp_bus.right_out;
            if (expected_speeds.size() == 0) begin
               $error("Result left_out=%0d right_out=%0d arrived with nothing expected",
                      got.left_out, got.right_out);
               err_cnt = err_cnt + 1;
            end else begin
               want = expected_speeds.pop_front();
               if (got.left_out !== want.left_out) begin
                  $error("left_out mismatch: expected %0d, actual %0d",
                         want.left_out, got.left_out);
                  err_cnt = err_cnt + 1;
               end
               if (got.right_out !== want.right_out) begin
                  $error("right_out mismatch: expected %0d, actual %0d",
                         want.right_out, got.right_out);
                  err_cnt = err_cnt + 1;
               end
               checked_cnt = checked_cnt + 1;
            end
         end

         // Cycles without any command or result in flight, used to gate register writes.
         if (expected_speeds.size() == 0 && !req_bus.valid && !rsp_bus.valid) begin
            quiet_cnt = quiet_cnt + 1;
         end else begin
            quiet_cnt = 0;
         end
      end
   end

endmodule
